// ===== hdl/bmhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhpq_pkg: shared types and codes of the min-heap priority queue
// Entry layout, request kinds, status codes and item field widths.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

    // item field widths
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned PAY_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 11;

    // packed stream widths (result tdata filled up to whole bytes)
    localparam int unsigned S_TDATA_W   = KEY_W + PAY_W;
    localparam int unsigned M_FIELDS_W  = STATUS_W + KEY_W + PAY_W + COUNT_W;
    localparam int unsigned M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // one heap entry, key in the upper half
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    // request kind carried on s_tuser
    typedef enum logic {
        REQ_INSERT  = 1'b0,
        REQ_EXTRACT = 1'b1
    } req_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

// ===== hdl/binary_min_heap_priority_queue.sv =====
// Flow: insert sifts up and extract sifts down through L heap levels to the result register,
// where L is at most log2(CAPACITY); full and empty requests go straight to the result register.
// One item at a time: a new request is taken only once the last result is loaded into the output
// register; the sift loop does one heap level per cycle through the entry memory.
// Reset: aresetn clears the fill count, the controller and the result valid; the entry
// memory is not cleared, only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue
// Min-heap of key and payload entries held in one synchronous memory with
// one write and two read ports; insert sifts up, extract sifts down.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmhpq_pkg::S_TDATA_W-1:0]   s_tdata,   // key[31:0], payload[63:32]
    input  logic                              s_tuser,   // req_type[0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bmhpq_pkg::M_TDATA_W-1:0]   m_tdata    // status[1:0], out_key[33:2],
                                                         // out_payload[65:34],
                                                         // entry_count[76:66], zero above
);
    import bmhpq_pkg::*;

    // index, count and child index widths
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = IW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_FIN,
        S_DN_LOAD,
        S_DN_CMP,
        S_RESULT
    } state_t;

    // entry memory
    entry_t mem [CAPACITY];

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    logic [XW-1:0] rd_a_idx;
    logic [XW-1:0] rd_b_idx;
    entry_t        rd_a_reg;
    entry_t        rd_b_reg;

    // control and payload registers
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [XW-1:0]  at_reg, at_next;
    entry_t         cand_reg, cand_next;
    status_t        res_status_reg, res_status_next;
    entry_t         res_entry_reg, res_entry_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // helpers
    entry_t         s_entry;
    logic           accept;
    logic [XW-1:0]  count_x;
    logic [XW-1:0]  parent_idx;
    logic [XW-1:0]  child_idx;
    logic [XW-1:0]  right_idx;
    logic           right_pick;
    entry_t         sel_entry;
    logic [XW-1:0]  sel_idx;
    logic [CW+COUNT_W-1:0] count_wide;

    assign s_entry    = '{key: s_tdata[KEY_W-1:0], payload: s_tdata[S_TDATA_W-1:KEY_W]};
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign count_x    = {{(XW-CW){1'b0}}, count_reg};
    assign parent_idx = (at_reg - XW'(1)) >> 1;
    assign child_idx  = {at_reg[XW-2:0], 1'b1};
    assign right_idx  = child_idx + XW'(1);
    assign right_pick = (right_idx < count_x) && (rd_b_reg.key <= rd_a_reg.key);
    assign sel_entry  = right_pick ? rd_b_reg : rd_a_reg;
    assign sel_idx    = right_pick ? right_idx : child_idx;
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_idx[IW-1:0]];
        rd_b_reg <= mem[rd_b_idx[IW-1:0]];
    end

    // sift controller
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        at_next         = at_reg;
        cand_next       = cand_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;
        wr_addr         = at_reg[IW-1:0];
        wr_data         = cand_reg;
        rd_a_idx        = '0;
        rd_b_idx        = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_entry_next = '0;
                    if (s_tuser == REQ_INSERT) begin
                        if (count_reg >= CW'(CAPACITY)) begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESULT;
                        end else begin
                            res_status_next = ST_OK;
                            cand_next       = s_entry;
                            count_next      = count_reg + CW'(1);
                            at_next         = count_x;
                            if (count_reg == '0) begin
                                // empty heap: new entry becomes the root
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = s_entry;
                                state_next = S_RESULT;
                            end else begin
                                rd_a_idx   = (count_x - XW'(1)) >> 1;
                                state_next = S_UP_CMP;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_RESULT;
                        end else begin
                            // fetch root and last entry together
                            res_status_next = ST_OK;
                            count_next      = count_reg - CW'(1);
                            rd_a_idx        = '0;
                            rd_b_idx        = count_x - XW'(1);
                            state_next      = S_DN_LOAD;
                        end
                    end
                end
            end

            S_UP_CMP: begin
                if (rd_a_reg.key <= cand_reg.key) begin
                    wr_en      = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    // parent moves down one level
                    wr_en    = 1'b1;
                    wr_data  = rd_a_reg;
                    at_next  = parent_idx;
                    rd_a_idx = (parent_idx - XW'(1)) >> 1;
                    if (parent_idx == '0) begin
                        state_next = S_UP_FIN;
                    end
                end
            end

            S_UP_FIN: begin
                wr_en      = 1'b1;
                state_next = S_RESULT;
            end

            S_DN_LOAD: begin
                res_entry_next = rd_a_reg;
                cand_next      = rd_b_reg;
                at_next        = '0;
                rd_a_idx       = XW'(1);
                rd_b_idx       = XW'(2);
                state_next     = S_DN_CMP;
            end

            S_DN_CMP: begin
                if (child_idx >= count_x || cand_reg.key <= sel_entry.key) begin
                    wr_en      = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    // chosen child moves up one level
                    wr_en    = 1'b1;
                    wr_data  = sel_entry;
                    at_next  = sel_idx;
                    rd_a_idx = {sel_idx[XW-2:0], 1'b1};
                    rd_b_idx = {sel_idx[XW-2:0], 1'b1} + XW'(1);
                end
            end

            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({count_wide[COUNT_W-1:0],
                                                res_entry_reg.payload,
                                                res_entry_reg.key,
                                                res_status_reg});
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        at_reg         <= at_next;
        cand_reg       <= cand_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule
